// ----- rtl/kwl_pkg.sv -----
// shared types, token codes and keyword tables for the keyword token lexer
package kwl_pkg;

  localparam int NKEYS   = 15;
  localparam int KIND_W  = 6;
  localparam int LEN_W   = 5;
  localparam int Q_DEPTH = 2;

  localparam logic [KIND_W-1:0] K_END     = 6'd0;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd1;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd2;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd3;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd4;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd5;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd6;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd7;
  localparam logic [KIND_W-1:0] K_GT      = 6'd8;
  localparam logic [KIND_W-1:0] K_LT      = 6'd9;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd10;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd11;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd12;
  localparam logic [KIND_W-1:0] K_BANG    = 6'd13;
  localparam logic [KIND_W-1:0] K_AND     = 6'd14;
  localparam logic [KIND_W-1:0] K_OR      = 6'd15;
  localparam logic [KIND_W-1:0] K_NUMBER  = 6'd16;
  localparam logic [KIND_W-1:0] K_SYMBOL  = 6'd17;
  localparam logic [KIND_W-1:0] K_KEY0    = 6'd18;
  localparam logic [KIND_W-1:0] K_INVALID = 6'd33;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic [31:0]       mant;
    logic [4:0]        frac;
    logic              ovf;
  } tok_t;

  localparam logic [3:0] KW_LEN [NKEYS] = '{
    4'd3, 4'd4, 4'd7, 4'd8, 4'd7, 4'd11, 4'd8, 4'd9, 4'd5, 4'd4, 4'd5,
    4'd3, 4'd3, 4'd3, 4'd3
  };

  localparam logic [87:0] KW_STR [NKEYS] = '{
    "tap", "hold", "release", "downedge", "fasttap", "doubleclick",
    "holddown", "clickhold", "press", "true", "false", "ana", "rel",
    "seq", "get"
  };

  // character p of keyword k, first character at p = 0
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [3:0] d;
    d = KW_LEN[k] - 4'd1 - p;
    return KW_STR[k][{d, 3'b000} +: 8];
  endfunction

  function automatic logic [KIND_W-1:0] single_op(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      ";":     k = K_SEMI;
      "=":     k = K_ASSIGN;
      ",":     k = K_COMMA;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ">":     k = K_GT;
      "<":     k = K_LT;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "!":     k = K_BANG;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/kwl_front.sv -----
// front end: lexer state, character classification and token formation
module kwl_front #(
  parameter int MAX_TOKEN   = 24,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic                   in_kind,
  input  logic [7:0]             in_text_byte,
  output logic                   push,
  output kwl_pkg::tok_t          tok_a,
  output logic [OFFSET_BITS-1:0] start_a,
  output kwl_pkg::tok_t          tok_b,
  output logic [OFFSET_BITS-1:0] start_b,
  output logic                   has_b
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RUN     = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;
  localparam logic [1:0] MODE_HELD    = 2'd3;

  localparam int F_NUM   = 0;
  localparam int F_POINT = 1;
  localparam int F_STOP  = 2;
  localparam int F_OVF   = 3;

  logic [1:0]             mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [4:0]             rlen_r, rlen_nxt;
  logic [14:0]            cand_r, cand_nxt;
  logic [31:0]            val_r, val_nxt;
  logic [4:0]             dap_r, dap_nxt;
  logic [3:0]             flags_r, flags_nxt;

  kwl_pkg::tok_t          fin_tok;
  kwl_pkg::tok_t          toks [2];
  logic [OFFSET_BITS-1:0] starts [2];
  logic [1:0]             n;
  logic                   fresh;
  logic                   cont;
  logic [35:0]            v36;
  logic [4:0]             p;
  logic [7:0]             c;
  logic                   is_end;
  logic                   is_blank;
  logic                   is_hold;
  logic                   is_digit;
  logic                   is_run;
  logic [5:0]             op;

  function automatic kwl_pkg::tok_t short_tok(input logic [5:0] kind, input logic [4:0] len);
    kwl_pkg::tok_t t;
    t      = '0;
    t.kind = kind;
    t.len  = len;
    return t;
  endfunction

  assign c        = in_text_byte;
  assign is_end   = in_kind || (c == 8'd0);
  assign is_blank = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  assign is_hold  = (c == "/") || (c == "&") || (c == "|");
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_run   = is_digit || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
                    (c == ".") || (c == "_");
  assign op       = kwl_pkg::single_op(c);

  // token for the run in progress
  always_comb begin
    fin_tok     = '0;
    fin_tok.len = rlen_r;
    if (flags_r[F_NUM]) begin
      fin_tok.kind = kwl_pkg::K_NUMBER;
      fin_tok.mant = val_r;
      fin_tok.frac = dap_r;
      fin_tok.ovf  = flags_r[F_OVF];
    end else begin
      fin_tok.kind = kwl_pkg::K_SYMBOL;
      for (int k = 0; k < kwl_pkg::NKEYS; k++) begin
        if (cand_r[k] && ({1'b0, kwl_pkg::KW_LEN[k]} == rlen_r)) begin
          fin_tok.kind = kwl_pkg::K_KEY0 + 6'(k);
        end
      end
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    rlen_nxt   = rlen_r;
    cand_nxt   = cand_r;
    val_nxt    = val_r;
    dap_nxt    = dap_r;
    flags_nxt  = flags_r;
    toks[0]    = '0;
    toks[1]    = '0;
    starts[0]  = '0;
    starts[1]  = '0;
    n          = 2'd0;
    fresh      = 1'b0;
    cont       = 1'b0;
    v36        = '0;
    p          = '0;
    if (is_end) begin
      if (mode_r == MODE_RUN) begin
        toks[0]   = fin_tok;
        starts[0] = tstart_r;
        n         = 2'd1;
      end else if (mode_r == MODE_HELD) begin
        toks[0]   = short_tok(kwl_pkg::K_INVALID, 5'd1);
        starts[0] = tstart_r;
        n         = 2'd1;
      end
      toks[n[0]]   = short_tok(kwl_pkg::K_END, 5'd0);
      starts[n[0]] = pos_r;
      n            = n + 2'd1;
      mode_nxt     = MODE_IDLE;
      held_nxt     = '0;
      pos_nxt      = '0;
      tstart_nxt   = '0;
      rlen_nxt     = '0;
      cand_nxt     = '1;
      val_nxt      = '0;
      dap_nxt      = '0;
      flags_nxt    = '0;
    end else begin
      unique case (mode_r)
        MODE_RUN: begin
          if (is_run) begin
            cont = 1'b1;
          end else begin
            toks[0]   = fin_tok;
            starts[0] = tstart_r;
            n         = 2'd1;
            mode_nxt  = MODE_IDLE;
            fresh     = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if ((c == 8'h0A) || (c == 8'h0D)) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_HELD: begin
          mode_nxt = MODE_IDLE;
          if ((held_r == "/") && (c == "/")) begin
            mode_nxt = MODE_COMMENT;
          end else if ((held_r == "&") && (c == "&")) begin
            toks[0]   = short_tok(kwl_pkg::K_AND, 5'd2);
            starts[0] = tstart_r;
            n         = 2'd1;
          end else if ((held_r == "|") && (c == "|")) begin
            toks[0]   = short_tok(kwl_pkg::K_OR, 5'd2);
            starts[0] = tstart_r;
            n         = 2'd1;
          end else begin
            toks[0]   = short_tok(kwl_pkg::K_INVALID, 5'd1);
            starts[0] = tstart_r;
            n         = 2'd1;
            fresh     = 1'b1;
          end
        end
        MODE_IDLE: begin
          fresh = 1'b1;
        end
      endcase

      if (fresh && !is_blank) begin
        priority if (is_hold) begin
          mode_nxt   = MODE_HELD;
          held_nxt   = c;
          tstart_nxt = pos_r;
        end else if (op != kwl_pkg::K_END) begin
          toks[n[0]]   = short_tok(op, 5'd1);
          starts[n[0]] = pos_r;
          n            = n + 2'd1;
        end else if (is_run) begin
          mode_nxt   = MODE_RUN;
          tstart_nxt = pos_r;
          rlen_nxt   = '0;
          cand_nxt   = '1;
          val_nxt    = '0;
          dap_nxt    = '0;
          flags_nxt  = '0;
          flags_nxt[F_NUM] = is_digit || (c == ".");
          cont       = 1'b1;
        end else begin
          toks[n[0]]   = short_tok(kwl_pkg::K_INVALID, 5'd1);
          starts[n[0]] = pos_r;
          n            = n + 2'd1;
        end
      end

      if (cont) begin
        p = rlen_nxt;
        for (int k = 0; k < kwl_pkg::NKEYS; k++) begin
          if ({1'b0, kwl_pkg::KW_LEN[k]} <= p) begin
            cand_nxt[k] = 1'b0;
          end else if (kwl_pkg::kw_char(4'(k), p[3:0]) != c) begin
            cand_nxt[k] = 1'b0;
          end
        end
        if (flags_nxt[F_NUM] && !flags_nxt[F_STOP]) begin
          if (is_digit) begin
            if (!flags_nxt[F_OVF]) begin
              v36 = ({4'd0, val_nxt} << 3) + ({4'd0, val_nxt} << 1) + {32'd0, c[3:0]};
              if (v36[35:32] != 4'd0) begin
                val_nxt          = '1;
                flags_nxt[F_OVF] = 1'b1;
              end else begin
                val_nxt = v36[31:0];
              end
            end
            if (flags_nxt[F_POINT] && (dap_nxt != 5'd31)) begin
              dap_nxt = dap_nxt + 5'd1;
            end
          end else if ((c == ".") && !flags_nxt[F_POINT]) begin
            flags_nxt[F_POINT] = 1'b1;
          end else begin
            flags_nxt[F_STOP] = 1'b1;
          end
        end
        rlen_nxt = rlen_nxt + 5'd1;
        if (rlen_nxt >= 5'(MAX_TOKEN)) begin
          toks[n[0]]   = short_tok(kwl_pkg::K_INVALID, rlen_nxt);
          starts[n[0]] = tstart_nxt;
          n            = n + 2'd1;
          mode_nxt     = MODE_IDLE;
        end
      end

      pos_nxt = pos_r + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      held_r   <= '0;
      pos_r    <= '0;
      tstart_r <= '0;
      rlen_r   <= '0;
      cand_r   <= '1;
      val_r    <= '0;
      dap_r    <= '0;
      flags_r  <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      rlen_r   <= rlen_nxt;
      cand_r   <= cand_nxt;
      val_r    <= val_nxt;
      dap_r    <= dap_nxt;
      flags_r  <= flags_nxt;
    end
  end

  assign push    = acc && (n != 2'd0);
  assign tok_a   = toks[0];
  assign start_a = starts[0];
  assign tok_b   = toks[1];
  assign start_b = starts[1];
  assign has_b   = n[1];

endmodule

// ----- rtl/kwl_fifo.sv -----
// short queue of token groups between the front and back ends
module kwl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign full   = (count_r == CW'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

endmodule

// ----- rtl/kwl_back.sv -----
// back end: output register that hands out the tokens of each group in order
module kwl_back #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ent_valid,
  input  kwl_pkg::tok_t          tok_a,
  input  logic [OFFSET_BITS-1:0] start_a,
  input  kwl_pkg::tok_t          tok_b,
  input  logic [OFFSET_BITS-1:0] start_b,
  input  logic                   has_b,
  output logic                   pop,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [5:0]             out_token_kind,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [4:0]             out_token_length,
  output logic [31:0]            out_mantissa,
  output logic [4:0]             out_fraction_digits,
  output logic                   out_mantissa_overflow,
  output logic                   out_last_of_run
);

  kwl_pkg::tok_t          tok_a_r;
  kwl_pkg::tok_t          tok_b_r;
  logic [OFFSET_BITS-1:0] start_a_r;
  logic [OFFSET_BITS-1:0] start_b_r;
  logic                   has_b_r;
  logic                   busy_r;
  logic                   sel_r;
  logic                   last_shown;
  kwl_pkg::tok_t          cur;

  assign last_shown = sel_r || !has_b_r;
  assign pop        = ent_valid && (!busy_r || (out_ready && last_shown));

  always_ff @(posedge clk) begin
    if (pop) begin
      tok_a_r   <= tok_a;
      tok_b_r   <= tok_b;
      start_a_r <= start_a;
      start_b_r <= start_b;
      has_b_r   <= has_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
      sel_r  <= 1'b0;
    end else if (busy_r && out_ready) begin
      if (last_shown) begin
        busy_r <= 1'b0;
        sel_r  <= 1'b0;
      end else begin
        sel_r <= 1'b1;
      end
    end
  end

  assign cur                   = sel_r ? tok_b_r : tok_a_r;
  assign out_valid             = busy_r;
  assign out_token_kind        = cur.kind;
  assign out_start_offset      = sel_r ? start_b_r : start_a_r;
  assign out_token_length      = cur.len;
  assign out_mantissa          = cur.mant;
  assign out_fraction_digits   = cur.frac;
  assign out_mantissa_overflow = cur.ovf;
  assign out_last_of_run       = last_shown;

  // second token only shown for a two-token group
  a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (busy_r && has_b_r))
    else $error("second token selected without a two-token group");

  // first of two tokens taken, second follows
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !sel_r && has_b_r && out_ready) |=> (busy_r && sel_r))
    else $error("second token of group lost");

  // no new group while an unfinished one is shown
  a_no_early_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !last_shown) |-> !pop)
    else $error("group replaced before its last token");

endmodule

// ----- rtl/keyword_token_lexer_unit.sv -----
// top level of the keyword token lexer: front end, token queue and back end
// the first token of an item goes through the token queue and then the back-end output register before it is offered
// throughput: one byte per cycle while in_ready is high; the output port hands out one token
// per cycle while out_ready is high, so an item that yields two tokens holds the output until both are taken
// the two-entry queue between front and back end sets in_ready
// reset: synchronous, clears lexer state to between tokens, offset to zero, queue empty
module keyword_token_lexer_unit #(
  parameter int MAX_TOKEN   = 24,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_kind,
  input  logic [7:0]             in_text_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_token_kind,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [4:0]             out_token_length,
  output logic [31:0]            out_mantissa,
  output logic [4:0]             out_fraction_digits,
  output logic                   out_mantissa_overflow,
  output logic                   out_last_of_run
);

  localparam int TW = $bits(kwl_pkg::tok_t);
  localparam int EW = 1 + 2 * (TW + OFFSET_BITS);

  logic                   acc;
  logic                   push;
  logic                   q_full;
  logic                   q_rvalid;
  logic                   pop;
  logic [EW-1:0]          q_wdata;
  logic [EW-1:0]          q_rdata;
  kwl_pkg::tok_t          f_tok_a, f_tok_b, q_tok_a, q_tok_b;
  logic [OFFSET_BITS-1:0] f_start_a, f_start_b, q_start_a, q_start_b;
  logic                   f_has_b, q_has_b;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  kwl_front #(
    .MAX_TOKEN   (MAX_TOKEN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .in_kind      (in_kind),
    .in_text_byte (in_text_byte),
    .push         (push),
    .tok_a        (f_tok_a),
    .start_a      (f_start_a),
    .tok_b        (f_tok_b),
    .start_b      (f_start_b),
    .has_b        (f_has_b)
  );

  assign q_wdata = {f_has_b, f_tok_b, f_start_b, f_tok_a, f_start_a};

  kwl_fifo #(
    .WIDTH (EW),
    .DEPTH (kwl_pkg::Q_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (q_wdata),
    .pop    (pop),
    .full   (q_full),
    .rvalid (q_rvalid),
    .rdata  (q_rdata)
  );

  assign {q_has_b, q_tok_b, q_start_b, q_tok_a, q_start_a} = q_rdata;

  kwl_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ent_valid             (q_rvalid),
    .tok_a                 (q_tok_a),
    .start_a               (q_start_a),
    .tok_b                 (q_tok_b),
    .start_b               (q_start_b),
    .has_b                 (q_has_b),
    .pop                   (pop),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_token_kind        (out_token_kind),
    .out_start_offset      (out_start_offset),
    .out_token_length      (out_token_length),
    .out_mantissa          (out_mantissa),
    .out_fraction_digits   (out_fraction_digits),
    .out_mantissa_overflow (out_mantissa_overflow),
    .out_last_of_run       (out_last_of_run)
  );

endmodule

// ----- bench/tb_keyword_token_lexer_unit.sv -----
// self-checking testbench for the keyword token lexer with its own token predictor
module tb_keyword_token_lexer_unit;

  localparam int MAX_TOKEN   = 24;
  localparam int OFFSET_BITS = 16;
  localparam int CYCLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 150;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._";
  localparam string OP_CHARS   = ";=,{}()><+-*!";
  localparam string HOLD_CHARS = "/&|";
  localparam string NEXT_CHARS = "/&|;a1 ";

  typedef enum logic [1:0] {LX_IDLE, LX_RUN, LX_COMMENT, LX_HELD} lex_mode_t;

  typedef struct {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [4:0]             len;
    logic [31:0]            mant;
    logic [4:0]             frac;
    logic                   ovf;
    logic                   last;
  } token_t;

  class lexer_scoreboard;
    token_t    expected_q[$];
    token_t    step_q[$];
    int        errors;
    string     kw_names[15];
    lex_mode_t mode;
    logic [7:0]             held;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] tok_start;
    int                     run_len;
    logic [14:0]            cands;
    logic [31:0]            value;
    logic [4:0]             frac;
    bit is_num, point_seen, stopped, ovf;

    function new();
      kw_names = '{"tap", "hold", "release", "downedge", "fasttap", "doubleclick",
                   "holddown", "clickhold", "press", "true", "false", "ana", "rel",
                   "seq", "get"};
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = LX_IDLE;
      held = '0;
      pos = '0;
      tok_start = '0;
      run_len = 0;
      cands = '1;
      value = '0;
      frac = '0;
      is_num = 0;
      point_seen = 0;
      stopped = 0;
      ovf = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_token(logic [5:0] kind, logic [OFFSET_BITS-1:0] start, int len,
                            logic [31:0] mant, logic [4:0] fd, logic of);
      token_t t;
      t.kind = kind;
      t.start = start;
      t.len = 5'(len);
      t.mant = mant;
      t.frac = fd;
      t.ovf = of;
      t.last = 1'b0;
      step_q.push_back(t);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit word_char(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "." || c == "_";
    endfunction

    function logic [5:0] op_code(logic [7:0] c);
      case (c)
        ";": return kwl_pkg::K_SEMI;
        "=": return kwl_pkg::K_ASSIGN;
        ",": return kwl_pkg::K_COMMA;
        "{": return kwl_pkg::K_LBRACE;
        "}": return kwl_pkg::K_RBRACE;
        "(": return kwl_pkg::K_LPAREN;
        ")": return kwl_pkg::K_RPAREN;
        ">": return kwl_pkg::K_GT;
        "<": return kwl_pkg::K_LT;
        "+": return kwl_pkg::K_PLUS;
        "-": return kwl_pkg::K_MINUS;
        "*": return kwl_pkg::K_STAR;
        "!": return kwl_pkg::K_BANG;
        default: return kwl_pkg::K_END;
      endcase
    endfunction

    function void close_run();
      logic [5:0] kind;
      if (is_num) begin
        add_token(kwl_pkg::K_NUMBER, tok_start, run_len, value, frac, ovf);
      end else begin
        kind = kwl_pkg::K_SYMBOL;
        for (int k = 0; k < 15; k++)
          if (cands[k] && kw_names[k].len() == run_len) kind = kwl_pkg::K_KEY0 + 6'(k);
        add_token(kind, tok_start, run_len, '0, '0, 1'b0);
      end
      mode = LX_IDLE;
    endfunction

    function void grow_run(logic [7:0] c);
      logic [63:0] wide;
      for (int k = 0; k < 15; k++)
        if (run_len >= kw_names[k].len() || kw_names[k][run_len] != c) cands[k] = 1'b0;
      if (is_num && !stopped) begin
        if (is_digit(c)) begin
          if (!ovf) begin
            wide = {32'd0, value} * 64'd10 + {56'd0, c - 8'd48};
            if (wide > 64'hFFFF_FFFF) begin
              value = '1;
              ovf = 1;
            end else begin
              value = wide[31:0];
            end
          end
          if (point_seen && frac < 5'd31) frac = frac + 5'd1;
        end else if (c == "." && !point_seen) begin
          point_seen = 1;
        end else begin
          stopped = 1;
        end
      end
      run_len++;
      if (run_len >= MAX_TOKEN) begin
        add_token(kwl_pkg::K_INVALID, tok_start, run_len, '0, '0, 1'b0);
        mode = LX_IDLE;
      end
    endfunction

    function void fresh(logic [7:0] c);
      logic [5:0] op;
      op = op_code(c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
      if (c == "/" || c == "&" || c == "|") begin
        mode = LX_HELD;
        held = c;
        tok_start = pos;
      end else if (op != kwl_pkg::K_END) begin
        add_token(op, pos, 1, '0, '0, 1'b0);
      end else if (word_char(c)) begin
        mode = LX_RUN;
        tok_start = pos;
        run_len = 0;
        cands = '1;
        value = '0;
        frac = '0;
        is_num = is_digit(c) || c == ".";
        point_seen = 0;
        stopped = 0;
        ovf = 0;
        grow_run(c);
      end else begin
        add_token(kwl_pkg::K_INVALID, pos, 1, '0, '0, 1'b0);
      end
    endfunction

    // work out the tokens that one accepted item causes
    function void note_item(logic kind, logic [7:0] c);
      step_q.delete();
      if (kind || c == 8'd0) begin
        if (mode == LX_RUN) close_run();
        else if (mode == LX_HELD) add_token(kwl_pkg::K_INVALID, tok_start, 1, '0, '0, 1'b0);
        add_token(kwl_pkg::K_END, pos, 0, '0, '0, 1'b0);
        clear();
      end else begin
        case (mode)
          LX_RUN: begin
            if (word_char(c)) begin
              grow_run(c);
            end else begin
              close_run();
              fresh(c);
            end
          end
          LX_COMMENT: begin
            if (c == CH_LF || c == CH_CR) mode = LX_IDLE;
          end
          LX_HELD: begin
            mode = LX_IDLE;
            if (held == "/" && c == "/") begin
              mode = LX_COMMENT;
            end else if (held == "&" && c == "&") begin
              add_token(kwl_pkg::K_AND, tok_start, 2, '0, '0, 1'b0);
            end else if (held == "|" && c == "|") begin
              add_token(kwl_pkg::K_OR, tok_start, 2, '0, '0, 1'b0);
            end else begin
              add_token(kwl_pkg::K_INVALID, tok_start, 1, '0, '0, 1'b0);
              fresh(c);
            end
          end
          default: begin
            mode = LX_IDLE;
            fresh(c);
          end
        endcase
        pos = pos + 1'b1;
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void cmp(string fld, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, want, seen);
      end
    endfunction

    function void check(token_t got);
      token_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: token with none expected, actual kind %0d offset %0d",
                 $time, got.kind, got.start);
        return;
      end
      want = expected_q.pop_front();
      cmp("token_kind", 32'(want.kind), 32'(got.kind));
      cmp("start_offset", 32'(want.start), 32'(got.start));
      cmp("token_length", 32'(want.len), 32'(got.len));
      cmp("mantissa", want.mant, got.mant);
      cmp("fraction_digits", 32'(want.frac), 32'(got.frac));
      cmp("mantissa_overflow", 32'(want.ovf), 32'(got.ovf));
      cmp("last_of_run", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_kind;
  logic [7:0]             in_text_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [5:0]             out_token_kind;
  logic [OFFSET_BITS-1:0] out_start_offset;
  logic [4:0]             out_token_length;
  logic [31:0]            out_mantissa;
  logic [4:0]             out_fraction_digits;
  logic                   out_mantissa_overflow;
  logic                   out_last_of_run;

  lexer_scoreboard sb;
  logic [8:0] text_q[$];
  int  busy_items;
  int  cycles;
  int  hold_left;
  bit  hold_req;
  bit  quiet;

  keyword_token_lexer_unit #(
    .MAX_TOKEN(MAX_TOKEN),
    .OFFSET_BITS(OFFSET_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_text_byte(in_text_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_start_offset(out_start_offset),
    .out_token_length(out_token_length),
    .out_mantissa(out_mantissa),
    .out_fraction_digits(out_fraction_digits),
    .out_mantissa_overflow(out_mantissa_overflow),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_keyword_token_lexer_unit failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_kind, in_text_byte);
      if (out_valid && out_ready) begin
        got.kind = out_token_kind;
        got.start = out_start_offset;
        got.len = out_token_length;
        got.mant = out_mantissa;
        got.frac = out_fraction_digits;
        got.ovf = out_mantissa_overflow;
        got.last = out_last_of_run;
        sb.check(got);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 120;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = quiet || ($urandom_range(99) >= 20);
    end
  end

  task automatic push_item(logic [8:0] item);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = item[8];
    in_text_byte = item[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    logic [8:0] item;
    while (text_q.size() > 0) begin
      item = text_q.pop_front();
      busy_items++;
      push_item(item);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back({1'b0, s[i]});
  endfunction

  function automatic void add_byte(logic [7:0] b);
    text_q.push_back({1'b0, b});
  endfunction

  function automatic void add_end();
    text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic void add_word_char();
    add_byte(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) add_byte(8'd48 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_blank();
    case ($urandom_range(0, 3))
      0: add_byte(CH_TAB);
      1: add_byte(CH_LF);
      2: add_byte(CH_CR);
      default: add_byte(CH_SPACE);
    endcase
  endfunction

  function automatic void add_random_token();
    int    pick;
    int    n;
    string w;
    case ($urandom_range(0, 19))
      0, 1, 2: add_text(sb.kw_names[$urandom_range(0, 14)]);
      3: begin
        // near misses of a keyword
        w = sb.kw_names[$urandom_range(0, 14)];
        if ($urandom_range(1)) begin
          add_text(w);
          add_word_char();
        end else begin
          add_text(w.substr(0, w.len() - 2));
        end
      end
      4, 5: begin
        pick = $urandom_range(0, 52);
        add_byte(pick == 52 ? 8'h5F : WORD_CHARS[pick]);
        n = $urandom_range(0, 7);
        repeat (n) add_word_char();
      end
      6, 7: begin
        if ($urandom_range(4) == 0) add_byte(".");
        add_digits($urandom_range(1, 6));
        if ($urandom_range(1)) begin
          add_byte(".");
          add_digits($urandom_range(0, 4));
        end
        if ($urandom_range(3) == 0) add_word_char();
      end
      8: begin
        add_digits($urandom_range(10, 15));
        if ($urandom_range(1)) begin
          add_byte(".");
          add_digits($urandom_range(1, 5));
        end
      end
      9, 10, 11: add_byte(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)]);
      12: add_text($urandom_range(1) ? "&&" : "||");
      13: begin
        add_text("//");
        n = $urandom_range(0, 6);
        repeat (n) add_byte(8'($urandom_range(32, 126)));
        add_byte($urandom_range(1) ? CH_LF : CH_CR);
      end
      14: begin
        n = $urandom_range(20, 30);
        if ($urandom_range(1)) add_digits(1);
        repeat (n) add_word_char();
      end
      15: add_byte(8'($urandom_range(0, 255)));
      16: begin
        add_byte(HOLD_CHARS[$urandom_range(0, 2)]);
        add_byte(NEXT_CHARS[$urandom_range(0, 6)]);
      end
      17: add_end();
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) add_blank();
      end
    endcase
    if ($urandom_range(1)) add_blank();
  endfunction

  initial begin
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_text_byte = 8'd0;
    out_ready = 1'b0;
    hold_left = 0;
    hold_req = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    busy_items = 0;
    sb = new();
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every operator, lone ampersand and bar, a slash pending at end of string
    add_text(";=,{}()><+-*!&&||&|/");
    text_q.push_back({1'b1, 8'hFF});
    // saturated mantissa with fraction, comment, high stray byte, zero byte as end
    add_text("9999999999.05//x\n");
    add_byte(8'hFF);
    add_byte(8'h00);
    // over-long run, then a symbol left pending at end of string
    add_text("abcdefghijklmnopqrstuvwxyana");
    add_end();
    send_text();

    // mixed text with no idling on either side
    quiet = 1'b1;
    add_text("rel;12 seq get 3.25 && tap||x//c\nhold");
    add_end();
    send_text();

    // receiver holds off while the sender keeps offering items
    in_valid = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 30; i++) add_byte(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)]);
    send_text();
    quiet = 1'b0;
    in_valid = 1'b0;
    wait_drained();

    busy_items = 0;
    while (busy_items < RANDOM_ITEMS) begin
      add_random_token();
      send_text();
    end
    add_end();
    send_text();
    in_valid = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_keyword_token_lexer_unit passed");
    end else begin
      $display("tb_keyword_token_lexer_unit failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kwl_pkg.sv
rtl/kwl_front.sv
rtl/kwl_fifo.sv
rtl/kwl_back.sv
rtl/keyword_token_lexer_unit.sv
bench/tb_keyword_token_lexer_unit.sv
